@@ hw/rtl/gnst_pkg.sv @@
// ----------------------------------------------------------------------------
// gnst_pkg
// Types, codes and neighbour step tables for the grid neighbour sum table.
// ----------------------------------------------------------------------------
package gnst_pkg;

  localparam int unsigned VALUE_W   = 8;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned SIDE_W    = 5;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned SIDE_CMP_W = 7;
  localparam int unsigned VALUE_CNT = 256;
  localparam int unsigned MAX_SIDE  = 16;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_EDGE = 2'd1,
    OP_DIAG = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_POS  = 2'd1,
    ST_NB   = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

  typedef logic signed [1:0] step_t;

  typedef struct packed {
    step_t dr;
    step_t dc;
  } offset_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       load_we;
    logic       pos_rd;
    logic       nb_rd;
    logic [1:0] nb_idx;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
  } status_t;

  localparam offset_t EDGE_STEPS [4] = '{
    '{dr: -2'sd1, dc:  2'sd0},
    '{dr:  2'sd1, dc:  2'sd0},
    '{dr:  2'sd0, dc: -2'sd1},
    '{dr:  2'sd0, dc:  2'sd1}
  };

  localparam offset_t DIAG_STEPS [4] = '{
    '{dr: -2'sd1, dc: -2'sd1},
    '{dr: -2'sd1, dc:  2'sd1},
    '{dr:  2'sd1, dc: -2'sd1},
    '{dr:  2'sd1, dc:  2'sd1}
  };

  function automatic offset_t nb_step(input logic diag, input logic [1:0] idx);
    nb_step = diag ? DIAG_STEPS[idx] : EDGE_STEPS[idx];
  endfunction

endpackage

@@ hw/rtl/gnst_ctrl.sv @@
// ----------------------------------------------------------------------------
// gnst_ctrl
// Sequencer: accepts requests, steps the position and neighbour reads and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module gnst_ctrl
  import gnst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o,
  input  status_t    status_i
);

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  op_e        op;

  assign op = op_e'(op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op)
            OP_LOAD: cmd_o.load_we = 1'b1;
            OP_EDGE, OP_DIAG: begin
              cmd_o.capture = 1'b1;
              state_d       = ST_POS;
            end
            default: ;
          endcase
        end
      end
      ST_POS: begin
        cmd_o.pos_rd = 1'b1;
        cnt_d        = '0;
        state_d      = status_i.bad ? ST_FIN : ST_NB;
      end
      ST_NB: begin
        cmd_o.nb_rd  = 1'b1;
        cmd_o.nb_idx = cnt_q;
        cnt_d        = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/gnst_datapath.sv @@
// ----------------------------------------------------------------------------
// gnst_datapath
// Side length register, cell and position stores, neighbour addressing,
// accumulator and result register.
// ----------------------------------------------------------------------------
module gnst_datapath
  import gnst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               cfg_we_i,
  input  logic [SIDE_W-1:0]  cfg_wdata_i,
  input  logic [1:0]         op_i,
  input  logic [INDEX_W-1:0] row_index_i,
  input  logic [INDEX_W-1:0] col_index_i,
  input  logic [VALUE_W-1:0] cell_value_i,
  input  logic [VALUE_W-1:0] query_value_i,
  output logic [SUM_W-1:0]   neighbor_sum_o,
  output logic               bad_value_o
);

  localparam int unsigned CW    = $clog2(MAX_SIDE);
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned CELLS = 1 << AW;

  logic [VALUE_W-1:0] cell_mem [CELLS];
  logic [VALUE_W-1:0] pos_mem  [VALUE_CNT];

  logic [SIDE_W-1:0]  side_q;
  logic [SIDE_W-1:0]  side_use;
  logic [SUM_W-1:0]   side_sq;
  logic               load_ok;
  logic [AW-1:0]      wr_addr;

  logic [VALUE_W-1:0] query_q;
  logic               diag_q;
  logic               bad_q;
  logic [VALUE_W-1:0] pos_rd_q;
  logic [VALUE_W-1:0] cell_rd_q;
  logic               hit_q;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic [SUM_W-1:0]   total;
  logic [SUM_W-1:0]   sum_q;
  logic               bad_out_q;

  offset_t            step;
  logic signed [5:0]  nb_row, nb_col;
  logic               in_bounds;
  logic [AW-1:0]      rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
    end else if (cfg_we_i) begin
      side_q <= cfg_wdata_i;
    end
  end

  // saturate to the storage size
  assign side_use = (SIDE_CMP_W'(side_q) > SIDE_CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_q;
  assign side_sq  = SUM_W'(side_use) * SUM_W'(side_use);

  assign load_ok = (SIDE_CMP_W'(row_index_i) < SIDE_CMP_W'(MAX_SIDE)) &&
                   (SIDE_CMP_W'(col_index_i) < SIDE_CMP_W'(MAX_SIDE));
  assign wr_addr = {CW'(row_index_i), CW'(col_index_i)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && load_ok) begin
      cell_mem[wr_addr]     <= cell_value_i;
      pos_mem[cell_value_i] <= {row_index_i, col_index_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      query_q <= query_value_i;
      diag_q  <= (op_e'(op_i) == OP_DIAG);
      bad_q   <= (SUM_W'(query_value_i) >= side_sq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_rd) begin
      pos_rd_q <= pos_mem[query_q];
    end
  end

  // neighbour coordinates, one step from the looked-up position
  always_comb begin
    step      = nb_step(diag_q, cmd_i.nb_idx);
    nb_row    = $signed({2'b00, pos_rd_q[7:4]}) + 6'(step.dr);
    nb_col    = $signed({2'b00, pos_rd_q[3:0]}) + 6'(step.dc);
    in_bounds = !nb_row[5] && !nb_col[5] &&
                (nb_row[4:0] < side_use) && (nb_col[4:0] < side_use);
    rd_addr   = {CW'(nb_row[4:0]), CW'(nb_col[4:0])};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_rd && in_bounds) begin
      cell_rd_q <= cell_mem[rd_addr];
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.capture) begin
      acc_d = '0;
    end else if (cmd_i.nb_rd && hit_q) begin
      acc_d = acc_q + SUM_W'(cell_rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
      if (cmd_i.capture) begin
        hit_q <= 1'b0;
      end else if (cmd_i.nb_rd) begin
        hit_q <= in_bounds;
      end
    end
  end

  // fold in the last neighbour read
  assign total = bad_q ? '0 : (hit_q ? acc_q + SUM_W'(cell_rd_q) : acc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sum_q     <= total;
      bad_out_q <= bad_q;
    end
  end

  assign status_o.bad   = bad_q;
  assign neighbor_sum_o = sum_q;
  assign bad_value_o    = bad_out_q;

endmodule

@@ hw/rtl/grid_neighbor_sum_table.sv @@
// ----------------------------------------------------------------------------
// grid_neighbor_sum_table
// Square grid of distinct values with edge and diagonal neighbour sums.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         in_valid_i / in_ready_o    op, row/col index, values
//  result    out        out_valid_o / out_ready_i  neighbor_sum, bad_value
//  config    in         cfg_we_i                   side length (5 bits)
//
//  A load produces no result and leaves the request channel ready. A query
//  reads the position store once, then steps through four reads of the cell
//  store, then loads the result before the next request can be taken.
//  A bad query skips the neighbour reads.
//  A result held by out_ready_i low stalls only the next query at its end.
//  Reset is asynchronous, active low; the side length resets to 16.
// ----------------------------------------------------------------------------
module grid_neighbor_sum_table
  import gnst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SIDE_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [INDEX_W-1:0] row_index_i,
  input  logic [INDEX_W-1:0] col_index_i,
  input  logic [VALUE_W-1:0] cell_value_i,
  input  logic [VALUE_W-1:0] query_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SUM_W-1:0]   neighbor_sum_o,
  output logic               bad_value_o
);

  cmd_t    cmd;
  status_t status;

  gnst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  gnst_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .cell_value_i  (cell_value_i),
    .query_value_i (query_value_i),
    .neighbor_sum_o(neighbor_sum_o),
    .bad_value_o   (bad_value_o)
  );

endmodule

@@ hw/rtl/gnst_checker.sv @@
// ----------------------------------------------------------------------------
// gnst_checker
// Port-level checks on request and result sequencing.
// ----------------------------------------------------------------------------
module gnst_checker
  import gnst_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         op_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [SUM_W-1:0]   neighbor_sum_o,
  input logic               bad_value_o
);

  logic query_acc, load_acc;

  assign query_acc = in_valid_i && in_ready_o &&
                     (op_e'(op_i) == OP_EDGE || op_e'(op_i) == OP_DIAG);
  assign load_acc  = in_valid_i && in_ready_o && (op_e'(op_i) == OP_LOAD);

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(neighbor_sum_o) && $stable(bad_value_o))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_value_o |-> neighbor_sum_o == '0)
    else $error("bad query with non-zero sum");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken during a query");

  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> in_ready_o)
    else $error("load did not release the request channel");

  a_result_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without a query in flight");

endmodule

bind grid_neighbor_sum_table gnst_checker u_gnst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .neighbor_sum_o(neighbor_sum_o),
  .bad_value_o   (bad_value_o)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid neighbour sum table. The grid is filled
// with a shuffled set of all 256 values so that every lookup hits a written
// entry. A short directed pass covers the corners, field extremes, the bad
// value and empty grid cases, duplicate loads and the unused op code.
// Random load and query traffic then runs over several side lengths.
// Both handshakes idle at random, and a scoreboard predicts every result.
// ----------------------------------------------------------------------------
module tb_top
  import gnst_pkg::*;
();

  localparam int unsigned GRID   = 16;
  localparam int unsigned SETTLE = 10;
  localparam int unsigned LIMIT  = 2000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_REQS = 148;

  typedef struct {
    logic [SUM_W-1:0] sum;
    logic             bad;
  } nb_result_t;

  class neighbor_sum_scoreboard;
    logic [VALUE_W-1:0] cell_grid [GRID][GRID];
    logic [INDEX_W-1:0] value_row [VALUE_CNT];
    logic [INDEX_W-1:0] value_col [VALUE_CNT];
    logic [SIDE_W-1:0]  side_reg;
    nb_result_t         pending_sums[$];
    int failures, n_loads, n_edge, n_diag, n_ignored, n_results, n_bad;
    int edge_dr [4] = '{-1, 1, 0, 0};
    int edge_dc [4] = '{0, 0, -1, 1};
    int diag_dr [4] = '{-1, -1, 1, 1};
    int diag_dc [4] = '{-1, 1, -1, 1};

    function void set_side(logic [SIDE_W-1:0] v);
      side_reg = v;
    endfunction

    function int active_side();
      return (side_reg > GRID) ? int'(GRID) : int'(side_reg);
    endfunction

    function void predict_request(op_e op, logic [INDEX_W-1:0] row,
                                  logic [INDEX_W-1:0] col,
                                  logic [VALUE_W-1:0] cval,
                                  logic [VALUE_W-1:0] qval);
      nb_result_t res;
      int side, r, c, total;
      side = active_side();
      case (op)
        OP_LOAD: begin
          cell_grid[row][col] = cval;
          value_row[cval] = row;
          value_col[cval] = col;
          n_loads++;
        end
        OP_EDGE, OP_DIAG: begin
          if (op == OP_EDGE) n_edge++;
          else n_diag++;
          if (int'(qval) >= side * side) begin
            res.sum = '0;
            res.bad = 1'b1;
          end else begin
            total = 0;
            for (int k = 0; k < 4; k++) begin
              r = int'(value_row[qval]) + ((op == OP_EDGE) ? edge_dr[k] : diag_dr[k]);
              c = int'(value_col[qval]) + ((op == OP_EDGE) ? edge_dc[k] : diag_dc[k]);
              if (r >= 0 && c >= 0 && r < side && c < side)
                total += int'(cell_grid[r][c]);
            end
            res.sum = total[SUM_W-1:0];
            res.bad = 1'b0;
          end
          pending_sums.push_back(res);
        end
        default: n_ignored++;
      endcase
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
    endfunction

    function void check_result(logic [SUM_W-1:0] sum, logic bad);
      nb_result_t want;
      n_results++;
      if (bad) n_bad++;
      if (pending_sums.size() == 0) begin
        note_failure($sformatf("unexpected result sum=%0d bad=%0b", sum, bad));
        return;
      end
      want = pending_sums.pop_front();
      if (sum !== want.sum)
        note_failure($sformatf("neighbor_sum exp=%0d act=%0d", want.sum, sum));
      if (bad !== want.bad)
        note_failure($sformatf("bad_value exp=%0b act=%0b", want.bad, bad));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [SIDE_W-1:0]  cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         op_i;
  logic [INDEX_W-1:0] row_index_i;
  logic [INDEX_W-1:0] col_index_i;
  logic [VALUE_W-1:0] cell_value_i;
  logic [VALUE_W-1:0] query_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SUM_W-1:0]   neighbor_sum_o;
  logic               bad_value_o;

  grid_neighbor_sum_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .cell_value_i   (cell_value_i),
    .query_value_i  (query_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .neighbor_sum_o (neighbor_sum_o),
    .bad_value_o    (bad_value_o)
  );

  neighbor_sum_scoreboard sb;
  bit idle_on;
  bit req_up;
  int next_gap;
  int idle_cycles;
  int side_settings;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    op_i = OP_NONE;
    row_index_i = '0;
    col_index_i = '0;
    cell_value_i = '0;
    query_value_i = '0;
    out_ready_i = 1'b0;
    idle_on = 1'b1;
    req_up = 1'b0;
    next_gap = 0;
    idle_cycles = 0;
    side_settings = 0;
    sb = new();
    sb.set_side(SIDE_RESET);
  end

  always #2 clk_i = ~clk_i;

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 12)) : 0;
  endfunction

  task automatic send_request(op_e op, logic [INDEX_W-1:0] row, logic [INDEX_W-1:0] col,
                              logic [VALUE_W-1:0] cval, logic [VALUE_W-1:0] qval);
    // valid is already low when a gap is pending
    if (next_gap > 0) repeat (next_gap) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    op_i          <= op;
    row_index_i   <= row;
    col_index_i   <= col;
    cell_value_i  <= cval;
    query_value_i <= qval;
    req_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_request(op, row, col, cval, qval);
    next_gap = draw_gap();
    if (next_gap > 0) begin
      in_valid_i <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  task automatic drain_results();
    if (req_up) begin
      in_valid_i <= 1'b0;
      req_up = 1'b0;
    end
    while (sb.pending_sums.size() != 0) @(posedge clk_i);
    // a trailing load may still be in flight
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_side(logic [SIDE_W-1:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_side(v);
    side_settings++;
  endtask

  task automatic random_request();
    int side, pick;
    logic [VALUE_W-1:0] qval;
    side = sb.active_side();
    pick = $urandom_range(0, 99);
    if (side > 0 && $urandom_range(0, 99) < 80)
      qval = VALUE_W'($urandom_range(0, side * side - 1));
    else
      qval = VALUE_W'($urandom_range(0, 255));
    if (pick < 35)
      send_request(OP_LOAD, INDEX_W'($urandom_range(0, 15)), INDEX_W'($urandom_range(0, 15)),
                   VALUE_W'($urandom_range(0, 255)), VALUE_W'($urandom_range(0, 255)));
    else if (pick < 66)
      send_request(OP_EDGE, INDEX_W'($urandom_range(0, 15)), INDEX_W'($urandom_range(0, 15)),
                   VALUE_W'($urandom_range(0, 255)), qval);
    else if (pick < 96)
      send_request(OP_DIAG, INDEX_W'($urandom_range(0, 15)), INDEX_W'($urandom_range(0, 15)),
                   VALUE_W'($urandom_range(0, 255)), qval);
    else
      send_request(OP_NONE, INDEX_W'($urandom_range(0, 15)), INDEX_W'($urandom_range(0, 15)),
                   VALUE_W'($urandom_range(0, 255)), VALUE_W'($urandom_range(0, 255)));
  endtask

  // result side: hold ready low for a random stall after each result
  initial begin
    int rx_gap;
    rx_gap = 0;
    @(posedge rst_ni);
    forever begin
      if (rx_gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      rx_gap = draw_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(neighbor_sum_o, bad_value_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, LIMIT);
      $display("grid_neighbor_sum_table regression: fail");
      $finish;
    end
  end

  initial begin
    int perm [VALUE_CNT];
    int j, tmp;
    logic [VALUE_W-1:0] v;
    logic [SIDE_W-1:0] phase_side [PHASES];

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_side(5'd16);
    next_gap = draw_gap();

    // fill every cell with a shuffled value so no lookup hits an unwritten entry
    for (int i = 0; i < VALUE_CNT; i++) perm[i] = i;
    for (int i = VALUE_CNT - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < VALUE_CNT; i++)
      send_request(OP_LOAD, INDEX_W'(i / GRID), INDEX_W'(i % GRID), VALUE_W'(perm[i]),
                   VALUE_W'($urandom_range(0, 255)));

    // corners, centre and field extremes on the full grid
    send_request(OP_EDGE, 4'd0, 4'd0, 8'd0, sb.cell_grid[0][0]);
    send_request(OP_DIAG, 4'd15, 4'd15, 8'd255, sb.cell_grid[15][15]);
    send_request(OP_EDGE, 4'd0, 4'd15, 8'd0, sb.cell_grid[0][15]);
    send_request(OP_DIAG, 4'd7, 4'd8, 8'd0, sb.cell_grid[7][8]);
    send_request(OP_EDGE, 4'd0, 4'd0, 8'd0, 8'd255);
    send_request(OP_DIAG, 4'd15, 4'd15, 8'd255, 8'd0);
    send_request(OP_NONE, 4'd15, 4'd15, 8'd255, 8'd255);
    // duplicate value: the latest load moves its position
    v = sb.cell_grid[0][0];
    send_request(OP_LOAD, 4'd15, 4'd0, v, 8'd0);
    send_request(OP_EDGE, 4'd0, 4'd0, 8'd0, v);
    send_request(OP_LOAD, 4'd15, 4'd15, 8'd255, 8'd255);
    send_request(OP_DIAG, 4'd0, 4'd0, 8'd0, 8'd255);

    // empty grid: every query is a bad value; then side lengths 1 and 2
    write_side(5'd0);
    send_request(OP_EDGE, 4'd0, 4'd0, 8'd0, 8'd0);
    send_request(OP_DIAG, 4'd0, 4'd0, 8'd0, 8'd255);
    write_side(5'd1);
    send_request(OP_EDGE, 4'd0, 4'd0, 8'd0, 8'd0);
    send_request(OP_DIAG, 4'd0, 4'd0, 8'd0, 8'd1);
    write_side(5'd2);
    send_request(OP_EDGE, 4'd0, 4'd0, 8'd0, 8'd3);
    send_request(OP_DIAG, 4'd0, 4'd0, 8'd0, 8'd4);
    // oversize side length saturates to the full grid
    write_side(5'd31);
    send_request(OP_EDGE, 4'd0, 4'd0, 8'd0, 8'd255);
    send_request(OP_DIAG, 4'd0, 4'd0, 8'd0, 8'd0);

    phase_side[0] = 5'd16;
    phase_side[1] = SIDE_W'($urandom_range(3, 15));
    phase_side[2] = 5'd31;
    phase_side[3] = SIDE_W'($urandom_range(2, 16));
    phase_side[4] = 5'd1;
    phase_side[5] = SIDE_W'($urandom_range(0, 31));
    phase_side[6] = 5'd16;
    phase_side[7] = SIDE_W'($urandom_range(17, 30));

    for (int p = 0; p < PHASES; p++) begin
      write_side(phase_side[p]);
      // run two of the phases with back-to-back traffic and no idling on either side
      idle_on = !(p == 3 || p == 6);
      next_gap = draw_gap();
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (p == 1 && n == PHASE_REQS / 2) begin
          drain_results();
          next_gap = draw_gap();
        end
        random_request();
      end
    end

    idle_on = 1'b1;
    drain_results();
    if (sb.pending_sums.size() != 0)
      sb.note_failure($sformatf("%0d results never arrived", sb.pending_sums.size()));

    $display("Run: %0d loads, %0d edge and %0d diagonal queries, %0d unused-op requests",
             sb.n_loads, sb.n_edge, sb.n_diag, sb.n_ignored);
    $display("     %0d results checked (%0d bad value) over %0d side length settings",
             sb.n_results, sb.n_bad, side_settings);
    if (sb.failures == 0)
      $display("grid_neighbor_sum_table regression: pass");
    else
      $display("grid_neighbor_sum_table regression: fail");
    $finish;
  end

endmodule
